// File: hdl/ilp4_pkg.sv
// Package for the fourth-order low-pass IIR filter: default widths,
// fixed-point formats and the Q3.22 filter coefficients.
// No dependencies.
`default_nettype none

package ilp4_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int HISTORY_WIDTH_DEF = 32;

    localparam int TAPS       = 4;
    localparam int COEF_WIDTH = 25;   // signed Q3.22
    localparam int COEF_FRAC  = 22;
    localparam int HIST_FRAC  = 16;
    localparam int ACC_WIDTH  = 64;   // accumulator wraps at this width

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    // Feed-forward taps (symmetric): B0, B1, B2, B1, B0.
    localparam t_coef FF_COEF [TAPS+1] = '{
        t_coef'(9227), t_coef'(37329), t_coef'(56204), t_coef'(37329), t_coef'(9227)
    };

    // Feedback taps on y[n-1] .. y[n-4], signs folded in.
    localparam t_coef FB_COEF [TAPS] = '{
        t_coef'(11293583), t_coef'(-12026747), t_coef'(5886706), t_coef'(-1109393)
    };

endpackage

`default_nettype wire

// File: hdl/iir_lowpass_fourth_order.sv
// Top level of the fourth-order direct-form-I low-pass IIR filter.
// Depends on ilp4_pkg (widths, formats, coefficients).
// Channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------
// sample   | in        | i_valid / o_stall  | i_sample_in    (signed)
// filtered | out       | o_valid / i_stall  | o_filtered_out (signed)
//
// One item per cycle sustained unless the output stalls; an accepted sample
// goes through the input register and then the result register to o_valid.
// The rate is set by the feedback loop: the four output-history registers feed four of the
// nine products, one adder tree and a round/saturate step that closes back into the history.
// Reset (synchronous, active low) clears both histories and all valid flags.
// A stall on the output holds the result register; the input register then
// holds too and o_stall rises only while both stages are full.
`default_nettype none

module iir_lowpass_fourth_order
    import ilp4_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int HISTORY_WIDTH = HISTORY_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_out
);

    localparam int FF_PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int FB_PROD_W = HISTORY_WIDTH + COEF_WIDTH;

    // Saturation limits, sign-extended to the accumulator width.
    localparam logic signed [ACC_WIDTH-1:0] HIST_MAX =
        {{(ACC_WIDTH-HISTORY_WIDTH+1){1'b0}}, {(HISTORY_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic signed [ACC_WIDTH-1:0] SAMP_MAX =
        {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] SAMP_MIN = ~SAMP_MAX;

    localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
        ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [HISTORY_WIDTH:0] HIST_HALF =
        (HISTORY_WIDTH+1)'(64'sd1 <<< (HIST_FRAC - 1));

    // Input stage
    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;

    // Filter state, newest first
    logic signed [SAMPLE_WIDTH-1:0]  r_x_hist [TAPS];
    logic signed [HISTORY_WIDTH-1:0] r_y_hist [TAPS];

    // Result stage
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic                            w_advance;
    logic                            w_step;
    logic signed [ACC_WIDTH-1:0]     w_ff;
    logic signed [ACC_WIDTH-1:0]     w_acc;
    logic signed [ACC_WIDTH-1:0]     w_acc_shift;
    logic signed [HISTORY_WIDTH-1:0] n_y;
    logic signed [HISTORY_WIDTH:0]   w_y_shift;
    logic signed [ACC_WIDTH-1:0]     w_y_wide;
    logic signed [SAMPLE_WIDTH-1:0]  n_out;
    logic signed [FF_PROD_W-1:0]     w_ff_prod [TAPS+1];
    logic signed [FB_PROD_W-1:0]     w_fb_prod [TAPS];

    // Advance the pipeline whenever the result register is free or being taken.
    assign w_advance = !r_out_valid || !i_stall;
    assign w_step    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    // Products: feed-forward on the new sample and the input history,
    // feedback on the output history.
    always_comb begin
        w_ff_prod[0] = FF_PROD_W'(FF_COEF[0]) * FF_PROD_W'(r_in_sample);
        for (int i = 0; i < TAPS; i++) begin
            w_ff_prod[i+1] = FF_PROD_W'(FF_COEF[i+1]) * FF_PROD_W'(r_x_hist[i]);
            w_fb_prod[i]   = FB_PROD_W'(FB_COEF[i]) * FB_PROD_W'(r_y_hist[i]);
        end
    end

    // Sum in Q.22, move to Q.38, add the feedback terms; wrap at 64 bits.
    always_comb begin
        w_ff = '0;
        for (int i = 0; i <= TAPS; i++) begin
            w_ff = w_ff + ACC_WIDTH'(w_ff_prod[i]);
        end
        w_acc = w_ff <<< HIST_FRAC;
        for (int i = 0; i < TAPS; i++) begin
            w_acc = w_acc + ACC_WIDTH'(w_fb_prod[i]);
        end
    end

    // Round to Q.16 (ties up), saturate to the history width.
    always_comb begin
        w_acc_shift = (w_acc + ACC_HALF) >>> COEF_FRAC;
        if (w_acc_shift > HIST_MAX) begin
            n_y = HISTORY_WIDTH'(HIST_MAX);
        end else if (w_acc_shift < HIST_MIN) begin
            n_y = HISTORY_WIDTH'(HIST_MIN);
        end else begin
            n_y = HISTORY_WIDTH'(w_acc_shift);
        end
    end

    // Round the history value to an integer, saturate to the sample width.
    always_comb begin
        w_y_shift = ($signed({n_y[HISTORY_WIDTH-1], n_y}) + HIST_HALF) >>> HIST_FRAC;
        w_y_wide  = ACC_WIDTH'(w_y_shift);
        if (w_y_wide > SAMP_MAX) begin
            n_out = SAMPLE_WIDTH'(SAMP_MAX);
        end else if (w_y_wide < SAMP_MIN) begin
            n_out = SAMPLE_WIDTH'(SAMP_MIN);
        end else begin
            n_out = SAMPLE_WIDTH'(w_y_wide);
        end
    end

    // Input register: load on accept, drop the flag once the item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_sample <= i_sample_in;
        end
    end

    // Histories shift only when an item is filtered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_x_hist[i] <= '0;
                r_y_hist[i] <= '0;
            end
        end else if (w_step) begin
            for (int i = TAPS - 1; i > 0; i--) begin
                r_x_hist[i] <= r_x_hist[i-1];
                r_y_hist[i] <= r_y_hist[i-1];
            end
            r_x_hist[0] <= r_in_sample;
            r_y_hist[0] <= n_y;
        end
    end

    // Result register: hold while stalled, clear the flag once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_filtered_out = r_out;

endmodule

`default_nettype wire

// File: hdl/ilp4_checker.sv
// Port-level checker for the fourth-order low-pass IIR filter, bound to
// the top level. Depends on ilp4_pkg for the default sample width.
`default_nettype none

module ilp4_checker
    import ilp4_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic signed [SAMPLE_WIDTH-1:0] o_filtered_out
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered_out))
        else $error("stalled result changed");

    // Input stalls only while a result waits behind an output stall.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // An accepted item reaches o_valid when the output is free.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted item did not reach the output");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Output only follows an accepted sample.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> $past(i_valid, 2) || $past(o_stall, 2))
        else $error("result without a preceding item");

endmodule

bind iir_lowpass_fourth_order ilp4_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ilp4_checker (.*);

`default_nettype wire
